### design/lut3d_pkg.sv
// Shared constants and types for the 3D color lattice resampler.
package lut3d_pkg;

    localparam int GRID_MAX     = 33;
    localparam int HALF_DIM     = (GRID_MAX + 1) / 2;
    localparam int BANK_DEPTH   = HALF_DIM * HALF_DIM * HALF_DIM;
    localparam int BANK_AW      = $clog2(BANK_DEPTH);
    localparam int NUM_BANKS    = 8;
    localparam int VAL_W        = 16;
    localparam int ENTRY_W      = 3 * VAL_W;
    localparam int COORD_W      = 6;
    localparam int FULL_WEIGHT  = 64;
    localparam int AXW_W        = 7;
    localparam int W2_W         = 2 * AXW_W;
    localparam int W3_W         = 19;
    localparam int ACC_W        = 34;
    localparam int SCALED_W     = ACC_W + 8;
    localparam int TEX_W        = 18;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [BANK_AW-1:0] bank_addr_t;

endpackage

### design/lut3d_bank.sv
// One parity bank of the lattice store: single write port, registered read port.
module lut3d_bank
    import lut3d_pkg::*;
(
    input  logic       aclk,
    input  logic       wr_en,
    input  bank_addr_t wr_addr,
    input  entry_t     wr_data,
    input  logic       rd_en,
    input  bank_addr_t rd_addr,
    output entry_t     rd_data
);

    entry_t mem [BANK_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/lut3d_trilinear_resample.sv
// Top level of the 3D color lattice loader and trilinear resampler.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  s_tdata, s_tuser (kind)
//   m_*       out        m_tvalid / m_tready  m_tdata
//   cfg_*     in         cfg_we               cfg_wdata (lut_size)
//
// One transaction enters per cycle unless the output stalls; an evaluate
// result passes the eight-bank lattice read and the multiply chain.
// The lattice is split into eight banks by coordinate parity, so all eight
// corners are read in the same cycle. Reset clears control state only.
// A stalled output freezes the whole pipeline and holds s_tready low.
module lut3d_trilinear_resample
    import lut3d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // red_index, green_index, blue_index, red_value, green_value, blue_value
    input  logic [71:0] s_tdata,
    // kind
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // texel_address, pixel_argb
    output logic [55:0] m_tdata,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata
);

    logic [5:0] lut_size_reg;
    logic [5:0] n_eff;
    logic       en;
    logic       in_acc;

    logic [COORD_W-1:0] in_coord [3];
    entry_t             in_entry;

    logic [COORD_W-1:0] lo_next [3];
    logic [AXW_W-1:0]   w0_next [3];
    logic [AXW_W-1:0]   w1_next [3];
    logic               wr_ok_next;
    logic [2:0]         wbank_next;
    bank_addr_t         waddr_next;

    logic               a_valid_reg;
    logic               a_kind_reg;
    logic               a_wr_ok_reg;
    logic [2:0]         a_wbank_reg;
    bank_addr_t         a_waddr_reg;
    entry_t             a_wdata_reg;
    logic [COORD_W-1:0] a_lo_reg [3];
    logic [AXW_W-1:0]   a_w0_reg [3];
    logic [AXW_W-1:0]   a_w1_reg [3];
    logic [TEX_W-1:0]   a_tex_reg;

    bank_addr_t         raddr_next [NUM_BANKS];
    logic [W2_W-1:0]    wxy_next   [NUM_BANKS];
    logic [AXW_W-1:0]   wz_next    [NUM_BANKS];
    entry_t             rdata      [NUM_BANKS];

    logic               b_valid_reg;
    logic [TEX_W-1:0]   b_tex_reg;
    logic [W2_W-1:0]    b_wxy_reg  [NUM_BANKS];
    logic [AXW_W-1:0]   b_wz_reg   [NUM_BANKS];

    logic               c_valid_reg;
    logic [TEX_W-1:0]   c_tex_reg;
    logic [W3_W-1:0]    c_w_reg    [NUM_BANKS];
    entry_t             c_data_reg [NUM_BANKS];

    logic               d_valid_reg;
    logic [TEX_W-1:0]   d_tex_reg;
    logic [ACC_W-1:0]   d_prod_reg [NUM_BANKS][3];

    logic               e_valid_reg;
    logic [TEX_W-1:0]   e_tex_reg;
    logic [ACC_W-1:0]   e_sum_reg  [2][3];

    logic               m_valid_reg;
    logic [55:0]        m_data_reg;
    logic [55:0]        m_data_next;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign in_acc   = s_tvalid && en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign in_coord[0] = s_tdata[5:0];
    assign in_coord[1] = s_tdata[11:6];
    assign in_coord[2] = s_tdata[17:12];
    assign in_entry    = s_tdata[65:18];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lut_size_reg <= 6'(GRID_MAX);
        end else if (cfg_we) begin
            lut_size_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (lut_size_reg < 6'd2) begin
            n_eff = 6'd2;
        end else if (lut_size_reg > 6'(GRID_MAX)) begin
            n_eff = 6'(GRID_MAX);
        end else begin
            n_eff = lut_size_reg;
        end
    end

    always_comb begin
        logic [11:0] p;
        logic [5:0]  f;
        logic [5:0]  fr;
        logic [6:0]  c;
        logic [5:0]  nm1;
        logic [5:0]  hi;
        nm1 = n_eff - 6'd1;
        for (int a = 0; a < 3; a++) begin
            p  = 12'(n_eff) * 12'(in_coord[a]);
            f  = p[11:6];
            fr = p[5:0];
            c  = (fr != 6'd0) ? 7'(f) + 7'd1 : 7'(f);
            lo_next[a] = (f > nm1) ? nm1 : f;
            hi         = (c > 7'(nm1)) ? nm1 : c[5:0];
            if (hi == lo_next[a]) begin
                w0_next[a] = 7'(FULL_WEIGHT);
                w1_next[a] = '0;
            end else begin
                w0_next[a] = 7'(FULL_WEIGHT) - 7'(fr);
                w1_next[a] = 7'(fr);
            end
        end
        wr_ok_next = (in_coord[0] < 6'(GRID_MAX)) && (in_coord[1] < 6'(GRID_MAX))
                     && (in_coord[2] < 6'(GRID_MAX));
        wbank_next = {in_coord[0][0], in_coord[1][0], in_coord[2][0]};
        waddr_next = BANK_AW'(in_coord[0][5:1] * (HALF_DIM * HALF_DIM)
                              + in_coord[1][5:1] * HALF_DIM + in_coord[2][5:1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_kind_reg  <= s_tuser[0];
            a_wr_ok_reg <= wr_ok_next;
            a_wbank_reg <= wbank_next;
            a_waddr_reg <= waddr_next;
            a_wdata_reg <= in_entry;
            a_tex_reg   <= {~in_coord[2], ~in_coord[0], in_coord[1]};
            for (int a = 0; a < 3; a++) begin
                a_lo_reg[a] <= lo_next[a];
                a_w0_reg[a] <= w0_next[a];
                a_w1_reg[a] <= w1_next[a];
            end
        end
    end

    always_comb begin
        logic [COORD_W-1:0] sel  [3];
        logic [AXW_W-1:0]   wsel [3];
        logic               side;
        for (int k = 0; k < NUM_BANKS; k++) begin
            for (int a = 0; a < 3; a++) begin
                side    = a_lo_reg[a][0] ^ k[2-a];
                sel[a]  = a_lo_reg[a] + 6'(side);
                wsel[a] = side ? a_w1_reg[a] : a_w0_reg[a];
            end
            raddr_next[k] = BANK_AW'(sel[0][5:1] * (HALF_DIM * HALF_DIM)
                                     + sel[1][5:1] * HALF_DIM + sel[2][5:1]);
            wxy_next[k]   = W2_W'(wsel[0]) * W2_W'(wsel[1]);
            wz_next[k]    = wsel[2];
        end
    end

    for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
        lut3d_bank u_bank (
            .aclk    (aclk),
            .wr_en   (en && a_valid_reg && (a_kind_reg == KIND_LOAD) && a_wr_ok_reg
                      && (a_wbank_reg == 3'(k))),
            .wr_addr (a_waddr_reg),
            .wr_data (a_wdata_reg),
            .rd_en   (en),
            .rd_addr (raddr_next[k]),
            .rd_data (rdata[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg && (a_kind_reg == KIND_EVAL);
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            m_valid_reg <= e_valid_reg;
        end
    end

    always_comb begin
        logic [ACC_W-1:0]    sum;
        logic [SCALED_W-1:0] scaled;
        logic [7:0]          ch [3];
        for (int c = 0; c < 3; c++) begin
            sum    = e_sum_reg[0][c] + e_sum_reg[1][c];
            scaled = {sum, 8'd0} - SCALED_W'(sum);
            ch[c]  = scaled[SCALED_W-1:ACC_W];
        end
        m_data_next = {6'd0, 8'hFF, ch[0], ch[1], ch[2], e_tex_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_tex_reg <= a_tex_reg;
            c_tex_reg <= b_tex_reg;
            d_tex_reg <= c_tex_reg;
            e_tex_reg <= d_tex_reg;
            m_data_reg <= m_data_next;
            for (int k = 0; k < NUM_BANKS; k++) begin
                b_wxy_reg[k]  <= wxy_next[k];
                b_wz_reg[k]   <= wz_next[k];
                c_w_reg[k]    <= W3_W'(b_wxy_reg[k]) * W3_W'(b_wz_reg[k]);
                c_data_reg[k] <= rdata[k];
                for (int c = 0; c < 3; c++) begin
                    if (c_w_reg[k] == '0) begin
                        d_prod_reg[k][c] <= '0;
                    end else begin
                        d_prod_reg[k][c] <= ACC_W'(c_data_reg[k][c*VAL_W +: VAL_W])
                                            * ACC_W'(c_w_reg[k]);
                    end
                end
            end
            for (int h = 0; h < 2; h++) begin
                for (int c = 0; c < 3; c++) begin
                    e_sum_reg[h][c] <= d_prod_reg[4*h][c] + d_prod_reg[4*h+1][c]
                                       + d_prod_reg[4*h+2][c] + d_prod_reg[4*h+3][c];
                end
            end
        end
    end

endmodule
